/* hdl/bmp_pkg.sv */
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and codes for the BMP byte stream to RGB pixel decoder.
// ----------------------------------------------------------------------------
package bmp_pkg;

    // sizes
    localparam int MAX_DIM_DEF = 4096;
    localparam int PAL_DEPTH   = 256;
    localparam int PAL_AW      = 8;
    localparam int HDR_BYTES   = 54;
    localparam int OPQ_DEPTH   = 4;
    localparam int OUTQ_DEPTH  = 4;

    // header constants
    localparam logic [7:0]  SIG_B    = 8'h42;
    localparam logic [7:0]  SIG_M    = 8'h4D;
    localparam logic [31:0] INFO_HDR = 32'd40;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_DIM    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // palette entry byte lanes
    localparam logic [1:0] LANE_BLUE  = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_RED   = 2'd2;
    localparam logic [1:0] LANE_PAD   = 2'd3;

    // register indexes
    localparam logic REG_FILE_SIZE = 1'b0;

    // result slots of one request, in issue order
    localparam logic [3:0] SLOT_PEND = 4'd0;
    localparam logic [3:0] SLOT_DIM  = 4'd1;
    localparam logic [3:0] SLOT_PIX0 = 4'd2;
    localparam logic [3:0] SLOT_STAT = 4'd10;
    localparam logic [3:0] SLOT_DONE = 4'd11;

    typedef enum logic [1:0] {
        MODE_1,
        MODE_4,
        MODE_8,
        MODE_24
    } t_mode;

    // work handed from front to back for one input byte
    typedef struct packed {
        logic        pend;
        logic [1:0]  pend_st;
        logic        dim;
        logic [12:0] img_w;
        logic [12:0] img_h;
        logic [3:0]  npix;
        t_mode       mode;
        logic [7:0]  dbyte;
        logic [15:0] asm_gb;
        logic [11:0] col;
        logic [11:0] row;
        logic        stat;
        logic [1:0]  stat_val;
        logic        pal_we;
        logic [7:0]  pal_idx;
        logic [1:0]  pal_lane;
    } t_op;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [1:0]  status;
        logic        last;
    } t_res;

endpackage

/* hdl/bmp_stream_to_rgb_pixels.sv */
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb_pixels
// Uncompressed BMP byte stream decoder producing RGB pixels, dimensions
// and a final status.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  input     in         push / full                   data_byte, last_byte
//  result    out        empty / pop                   kind .. status, last
//  config    in         psel penable pwrite pready    paddr, pwdata, prdata
//
//  The parser takes one byte a cycle while full is low; bytes that carry work
//  become requests in a four-entry queue. The back end issues one result a
//  cycle while the result queue has room, so a 1-bit byte of up to eight
//  pixels stays there longer and a full queue raises full.
//  Reset is synchronous, active low; no memory clearing pass is needed.
//  A result waiting on pop does not stop input until both queues fill.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb_pixels #(
    parameter int MAX_DIM = bmp_pkg::MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // results
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [11:0] o_col,
    output logic [11:0] o_row,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [12:0] o_image_width,
    output logic [12:0] o_image_height,
    output logic [1:0]  o_status,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmp_pkg::*;

    logic [31:0] r_file_size;
    logic        op_push;
    logic        op_full;
    logic        op_empty;
    logic        op_pop;
    t_op         op_w;
    t_op         op_r;
    t_res        res;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FILE_SIZE) ? r_file_size : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_FILE_SIZE) begin
            r_file_size <= pwdata;
        end
    end

    // front: parse bytes into requests
    bmp_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_file_size (r_file_size),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_op_full   (op_full),
        .o_op_push   (op_push),
        .o_op        (op_w)
    );

    // request queue
    bmp_fifo #(
        .t_item (t_op),
        .DEPTH  (OPQ_DEPTH)
    ) u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_wdata (op_w),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_rdata (op_r),
        .o_empty (op_empty),
        .o_count ()
    );

    // back: expand requests into results
    bmp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op_r),
        .i_op_empty (op_empty),
        .o_op_pop   (op_pop),
        .o_res      (res),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    assign full           = op_full;
    assign o_kind         = res.kind;
    assign o_col          = res.col;
    assign o_row          = res.row;
    assign o_red          = res.red;
    assign o_green        = res.green;
    assign o_blue         = res.blue;
    assign o_image_width  = res.image_width;
    assign o_image_height = res.image_height;
    assign o_status       = res.status;
    assign o_last         = res.last;

    // checks
    a_opq_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_push |-> !op_full) else $error("request pushed into full queue");

    a_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_PIXEL) |->
        (o_status == ST_OK && o_image_width == '0 && o_image_height == '0))
        else $error("pixel carries dimension or status bits");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full)) else $error("queues not empty after reset");

endmodule

/* hdl/bmp_fifo.sv */
// ----------------------------------------------------------------------------
// bmp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module bmp_fifo #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_item                        i_wdata,
    output logic                         o_full,
    input  logic                         i_pop,
    output t_item                        o_rdata,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    // pointers wrap at DEPTH - 1, so depth need not be a power of two
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            push_ok;
    logic            pop_ok;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_rdata = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push_ok) - CW'(pop_ok);
        end
    end

endmodule

/* hdl/bmp_front.sv */
// ----------------------------------------------------------------------------
// bmp_front
// Byte parser: captures and checks the header, tracks palette and pixel
// positions, and hands a request for each byte with work to the back end.
// ----------------------------------------------------------------------------
module bmp_front #(
    parameter int MAX_DIM = bmp_pkg::MAX_DIM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_file_size,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic          i_op_full,
    output logic          o_op_push,
    output bmp_pkg::t_op  o_op
);
    import bmp_pkg::*;

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int P1W = DW + 16;
    localparam int LW  = P1W - 2;
    localparam int P2W = LW + DW;

    // header byte offsets
    localparam int OFS_SIZE = 2;
    localparam int OFS_OFF  = 10;
    localparam int OFS_ISZ  = 14;
    localparam int OFS_W    = 18;
    localparam int OFS_H    = 22;
    localparam int OFS_BPP  = 28;
    localparam int OFS_COMP = 30;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_DATA,
        PH_PAD,
        PH_DONE
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [31:0]     r_cnt, n_cnt;
    logic [DW-1:0]   r_col, n_col;
    logic [DW-1:0]   r_row, n_row;
    logic [1:0]      r_sub, n_sub;
    logic [1:0]      r_mod4, n_mod4;
    logic [15:0]     r_asm, n_asm;
    logic            r_pend, n_pend;
    logic [1:0]      r_pend_st, n_pend_st;

    // captured header fields
    logic [7:0]      r_sig0, r_sig1;
    logic [31:0]     r_size, r_off, r_isz, r_w, r_h, r_comp;
    logic [15:0]     r_bpp;
    logic [P1W-1:0]  r_prod1;
    logic [P2W-1:0]  r_prod2;

    logic            acc;
    logic [5:0]      hc;
    logic [P1W:0]    sum1;
    logic [LW-1:0]   line;
    logic            ovf;
    logic            indexed;
    logic [31:0]     ent4;
    logic [31:0]     off_m54;
    logic            hdr_ok;
    logic [1:0]      hdr_st;
    t_mode           mode;
    logic [DW-1:0]   remain;
    logic [3:0]      npix;
    logic [DW:0]     col_sum;
    logic [DW-1:0]   row_next;
    logic [1:0]      mod4_n;
    logic [9:0]      pidx;
    logic            start;
    logic            st_en;
    logic [1:0]      st_val;
    t_op             op;

    assign acc = i_push && !i_op_full;
    assign hc  = r_cnt[5:0];

    // row length and image size check terms
    assign sum1    = {1'b0, r_prod1} + (P1W + 1)'(31);
    assign line    = {sum1[P1W:5], 2'b00};
    assign ovf     = 64'(r_prod2) > 64'h0000_0000_FFFF_FFFF;
    assign indexed = (r_bpp == 16'd1) || (r_bpp == 16'd4) || (r_bpp == 16'd8);
    assign ent4    = (r_bpp == 16'd1) ? 32'd8 :
                     (r_bpp == 16'd4) ? 32'd64 :
                     (r_bpp == 16'd8) ? 32'd1024 : 32'd0;
    assign off_m54 = r_off - 32'(HDR_BYTES);

    // header verdict, in priority order
    always_comb begin
        hdr_ok = 1'b0;
        hdr_st = ST_OK;
        if (i_file_size < 32'(HDR_BYTES)) begin
            hdr_st = ST_INVALID;
        end else if (r_sig0 != SIG_B || r_sig1 != SIG_M) begin
            hdr_st = ST_UNSUPPORTED;
        end else if (r_comp != '0) begin
            hdr_st = ST_UNSUPPORTED;
        end else if (r_isz != INFO_HDR) begin
            hdr_st = ST_UNSUPPORTED;
        end else if (r_w > 32'(MAX_DIM) || r_h > 32'(MAX_DIM)) begin
            hdr_st = ST_INVALID;
        end else if (ovf) begin
            hdr_st = ST_INVALID;
        end else if (r_size != i_file_size || r_size < r_off) begin
            hdr_st = ST_INVALID;
        end else if (r_off < 32'(HDR_BYTES)) begin
            hdr_st = ST_INVALID;
        end else if (r_off > 32'(HDR_BYTES) && off_m54 != ent4) begin
            hdr_st = ST_INVALID;
        end else if (indexed && r_off == 32'(HDR_BYTES)) begin
            hdr_st = ST_INVALID;
        end else if (!indexed && r_bpp != 16'd24) begin
            hdr_st = ST_UNSUPPORTED;
        end else begin
            hdr_ok = 1'b1;
        end
    end

    // pixel geometry of the current byte
    always_comb begin
        case (r_bpp)
            16'd1:   mode = MODE_1;
            16'd4:   mode = MODE_4;
            16'd8:   mode = MODE_8;
            default: mode = MODE_24;
        endcase
    end

    assign remain = r_w[DW-1:0] - r_col;

    always_comb begin
        case (mode)
            MODE_1:  npix = (remain >= DW'(8)) ? 4'd8 : 4'(remain);
            MODE_4:  npix = (remain >= DW'(2)) ? 4'd2 : 4'd1;
            MODE_8:  npix = 4'd1;
            default: npix = (r_sub == 2'd2) ? 4'd1 : 4'd0;
        endcase
    end

    assign col_sum  = (DW + 1)'(r_col) + (DW + 1)'(npix);
    assign row_next = r_row + 1'b1;
    assign mod4_n   = r_mod4 + 2'd1;
    assign pidx     = r_cnt[9:0] - 10'(HDR_BYTES);

    // next state and request for the accepted byte
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_col     = r_col;
        n_row     = r_row;
        n_sub     = r_sub;
        n_mod4    = r_mod4;
        n_asm     = r_asm;
        n_pend    = r_pend;
        n_pend_st = r_pend_st;
        start     = 1'b0;
        st_en     = 1'b0;
        st_val    = ST_OK;
        op          = '0;
        op.pend     = r_pend;
        op.pend_st  = r_pend_st;
        op.img_w    = r_w[12:0];
        op.img_h    = r_h[12:0];
        op.mode     = mode;
        op.dbyte    = i_data_byte;
        op.asm_gb   = r_asm;
        op.col      = 12'(r_col);
        op.row      = 12'(r_h[DW-1:0] - DW'(1) - r_row);
        op.pal_idx  = pidx[9:2];
        op.pal_lane = pidx[1:0];
        if (acc) begin
            n_pend = 1'b0;
            case (r_phase)
                PH_HEADER: begin
                    n_cnt = r_cnt + 32'd1;
                    if (hc == 6'(HDR_BYTES - 1)) begin
                        if (!hdr_ok) begin
                            n_phase = PH_DONE;
                            st_en   = 1'b1;
                            st_val  = hdr_st;
                        end else begin
                            op.dim = 1'b1;
                            if (r_off == 32'(HDR_BYTES)) begin
                                start = 1'b1;
                            end else begin
                                n_phase = PH_PALETTE;
                            end
                        end
                    end
                end
                PH_PALETTE: begin
                    op.pal_we = (pidx[1:0] != LANE_PAD);
                    n_cnt     = r_cnt + 32'd1;
                    if (n_cnt >= r_off) begin
                        start = 1'b1;
                    end
                end
                PH_DATA: begin
                    op.npix = npix;
                    n_col   = col_sum[DW-1:0];
                    if (mode == MODE_24) begin
                        case (r_sub)
                            2'd0: begin
                                n_asm = {8'h00, i_data_byte};
                                n_sub = 2'd1;
                            end
                            2'd1: begin
                                n_asm = {i_data_byte, r_asm[7:0]};
                                n_sub = 2'd2;
                            end
                            default: begin
                                n_sub = 2'd0;
                            end
                        endcase
                    end
                    n_mod4 = mod4_n;
                    if (col_sum >= (DW + 1)'(r_w[DW-1:0])) begin
                        n_col = '0;
                        n_row = row_next;
                        if (row_next >= r_h[DW-1:0]) begin
                            n_phase = PH_DONE;
                            st_en   = 1'b1;
                            st_val  = ST_OK;
                        end else if (mod4_n != 2'd0) begin
                            n_phase = PH_PAD;
                        end
                    end
                end
                PH_PAD: begin
                    n_mod4 = mod4_n;
                    if (mod4_n == 2'd0) begin
                        n_phase = PH_DATA;
                    end
                end
                default: begin
                end
            endcase

            // start of pixel data
            if (start) begin
                n_col  = '0;
                n_row  = '0;
                n_sub  = '0;
                n_mod4 = '0;
                n_asm  = '0;
                if (r_w == '0 || r_h == '0) begin
                    n_phase = PH_DONE;
                    st_en   = 1'b1;
                    st_val  = ST_OK;
                end else begin
                    n_phase = PH_DATA;
                end
            end

            // end of file: short file check and restart
            if (i_last_byte) begin
                if (n_phase != PH_DONE) begin
                    st_en  = 1'b1;
                    st_val = ST_INVALID;
                end
                n_phase = PH_HEADER;
                n_cnt   = '0;
                n_col   = '0;
                n_row   = '0;
                n_sub   = '0;
                n_mod4  = '0;
                n_asm   = '0;
            end

            // a status beyond eight results waits for the next byte
            if (st_en) begin
                if (!r_pend && !op.dim && op.npix == 4'd8) begin
                    n_pend    = 1'b1;
                    n_pend_st = st_val;
                end else begin
                    op.stat     = 1'b1;
                    op.stat_val = st_val;
                end
            end
        end
    end

    assign o_op      = op;
    assign o_op_push = acc && (op.pend || op.dim || op.npix != 4'd0 || op.stat || op.pal_we);

    // header capture and size products
    always_ff @(posedge i_clk) begin
        if (acc && r_phase == PH_HEADER) begin
            if (hc == 6'd0) begin
                r_sig0 <= i_data_byte;
            end
            if (hc == 6'd1) begin
                r_sig1 <= i_data_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (hc == 6'(OFS_SIZE + k)) r_size[8*k +: 8] <= i_data_byte;
                if (hc == 6'(OFS_OFF + k))  r_off[8*k +: 8]  <= i_data_byte;
                if (hc == 6'(OFS_ISZ + k))  r_isz[8*k +: 8]  <= i_data_byte;
                if (hc == 6'(OFS_W + k))    r_w[8*k +: 8]    <= i_data_byte;
                if (hc == 6'(OFS_H + k))    r_h[8*k +: 8]    <= i_data_byte;
                if (hc == 6'(OFS_COMP + k)) r_comp[8*k +: 8] <= i_data_byte;
            end
            for (int k = 0; k < 2; k++) begin
                if (hc == 6'(OFS_BPP + k)) r_bpp[8*k +: 8] <= i_data_byte;
            end
            if (hc == 6'(OFS_BPP + 2)) begin
                r_prod1 <= P1W'(r_w[DW-1:0]) * P1W'(r_bpp);
            end
            if (hc == 6'(OFS_BPP + 3)) begin
                r_prod2 <= P2W'(line) * P2W'(r_h[DW-1:0]);
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_sub   <= '0;
            r_mod4  <= '0;
            r_asm   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_sub   <= n_sub;
            r_mod4  <= n_mod4;
            r_asm   <= n_asm;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_st <= n_pend_st;
    end

endmodule

/* hdl/bmp_back.sv */
// ----------------------------------------------------------------------------
// bmp_back
// Expands each request into result items, one a cycle while the result
// queue has room, with the palette lookup stage and the result queue.
// ----------------------------------------------------------------------------
module bmp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bmp_pkg::t_op  i_op,
    input  logic          i_op_empty,
    output logic          o_op_pop,
    output bmp_pkg::t_res o_res,
    output logic          o_empty,
    input  logic          i_pop
);
    import bmp_pkg::*;

    localparam int OCW = $clog2(OUTQ_DEPTH + 1);

    logic [3:0]        r_k;
    logic [3:0]        c0, c1, c2, cur;
    logic [2:0]        pix_i;
    logic              pix_after;
    logic              is_last;
    logic              room;
    logic              emit;
    logic              op_done;
    logic [PAL_AW-1:0] pal_addr;
    t_res              res;
    logic              use_pal;

    // palette memory and read stage
    logic [7:0]        r_pal_r [PAL_DEPTH];
    logic [7:0]        r_pal_g [PAL_DEPTH];
    logic [7:0]        r_pal_b [PAL_DEPTH];
    logic [7:0]        r_rd_r, r_rd_g, r_rd_b;
    logic              r_s1_v;
    logic              r_s1_pal;
    t_res              r_s1;
    t_res              q_wdata;
    logic [OCW-1:0]    q_count;

    // next slot of the request that has a result
    always_comb begin
        c0  = (r_k == SLOT_PEND && !i_op.pend) ? SLOT_DIM : r_k;
        c1  = (c0 == SLOT_DIM && !i_op.dim) ? SLOT_PIX0 : c0;
        c2  = (c1 >= SLOT_PIX0 && c1 < SLOT_STAT && (c1 - SLOT_PIX0) >= i_op.npix) ?
              SLOT_STAT : c1;
        cur = (c2 == SLOT_STAT && !i_op.stat) ? SLOT_DONE : c2;
    end

    assign pix_i     = 3'(cur - SLOT_PIX0);
    assign pix_after = (cur < SLOT_PIX0) ? (i_op.npix != 4'd0) :
                       (cur < SLOT_STAT && (cur - SLOT_PIX0 + 4'd1) < i_op.npix);
    assign is_last   = !((cur == SLOT_PEND && i_op.dim) || pix_after ||
                         (cur < SLOT_STAT && i_op.stat));

    // issue control
    assign room     = (4'(q_count) + 4'(r_s1_v)) < 4'(OUTQ_DEPTH);
    assign emit     = !i_op_empty && cur != SLOT_DONE && room;
    assign op_done  = !i_op_empty && (cur == SLOT_DONE || (emit && is_last));
    assign o_op_pop = op_done;

    // palette index of the current pixel
    always_comb begin
        case (i_op.mode)
            MODE_1:  pal_addr = {7'd0, i_op.dbyte[3'd7 - pix_i]};
            MODE_4:  pal_addr = (pix_i == 3'd0) ? {4'd0, i_op.dbyte[7:4]} :
                                                  {4'd0, i_op.dbyte[3:0]};
            default: pal_addr = i_op.dbyte;
        endcase
    end

    // result fields of the current slot
    always_comb begin
        res      = '0;
        res.last = is_last;
        use_pal  = 1'b0;
        case (cur)
            SLOT_PEND: begin
                res.kind   = KIND_STATUS;
                res.status = i_op.pend_st;
            end
            SLOT_DIM: begin
                res.kind         = KIND_DIM;
                res.image_width  = i_op.img_w;
                res.image_height = i_op.img_h;
            end
            SLOT_STAT: begin
                res.kind   = KIND_STATUS;
                res.status = i_op.stat_val;
            end
            default: begin
                res.kind  = KIND_PIXEL;
                res.col   = i_op.col + 12'(pix_i);
                res.row   = i_op.row;
                res.red   = i_op.dbyte;
                res.green = i_op.asm_gb[15:8];
                res.blue  = i_op.asm_gb[7:0];
                use_pal   = (i_op.mode != MODE_24);
            end
        endcase
    end

    // palette write on request retire, lookup on issue
    always_ff @(posedge i_clk) begin
        if (op_done && i_op.pal_we) begin
            case (i_op.pal_lane)
                LANE_BLUE:  r_pal_b[i_op.pal_idx] <= i_op.dbyte;
                LANE_GREEN: r_pal_g[i_op.pal_idx] <= i_op.dbyte;
                LANE_RED:   r_pal_r[i_op.pal_idx] <= i_op.dbyte;
                default: begin
                end
            endcase
        end
        if (emit) begin
            r_rd_r <= r_pal_r[pal_addr];
            r_rd_g <= r_pal_g[pal_addr];
            r_rd_b <= r_pal_b[pal_addr];
        end
    end

    // slot cursor and lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= SLOT_PEND;
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= emit;
            if (op_done) begin
                r_k <= SLOT_PEND;
            end else if (emit) begin
                r_k <= cur + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1     <= res;
            r_s1_pal <= use_pal;
        end
    end

    // merge palette color into the result
    always_comb begin
        q_wdata = r_s1;
        if (r_s1_pal) begin
            q_wdata.red   = r_rd_r;
            q_wdata.green = r_rd_g;
            q_wdata.blue  = r_rd_b;
        end
    end

    // result queue, room is reserved at issue
    bmp_fifo #(
        .t_item (t_res),
        .DEPTH  (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_v),
        .i_wdata (q_wdata),
        .o_full  (),
        .i_pop   (i_pop),
        .o_rdata (o_res),
        .o_empty (o_empty),
        .o_count (q_count)
    );

endmodule

/* tb/tb_bmp_stream_to_rgb_pixels.sv */
// ----------------------------------------------------------------------------
// tb_bmp_stream_to_rgb_pixels
// Streams BMP files byte by byte into the decoder and checks every pixel,
// dimensions and status result against a behavioral decoder kept in the
// testbench. Covers good 1-, 4- and 24-bit files, 8-bit files cut short,
// malformed headers and truncated files, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bmp_pkg::*;

// expected result store and bmp decoder behavior
class bmp_scoreboard;
    t_res    exp_q[$];
    int      errors;
    // decoder state
    logic [31:0] file_size;
    int          ph;
    logic [31:0] nbytes;
    logic [7:0]  hdr[HDR_BYTES];
    logic [23:0] pal[PAL_DEPTH];
    logic [31:0] colc, rowc, gb_acc, sub, mod4;
    logic        pend;
    logic [1:0]  pend_st;
    logic [31:0] w, h, bpp, off;
    int          nres;

    localparam int PH_HDR = 0, PH_PAL = 1, PH_DAT = 2, PH_PAD = 3, PH_DONE = 4;

    function new();
        errors = 0;
        file_size = 0;
        pend = 0;
        pend_st = ST_OK;
        w = 0; h = 0; bpp = 0; off = 0;
        for (int i = 0; i < PAL_DEPTH; i++) pal[i] = '0;
        for (int i = 0; i < HDR_BYTES; i++) hdr[i] = '0;
        restart();
    endfunction

    function void restart();
        ph = PH_HDR; nbytes = 0; colc = 0; rowc = 0; gb_acc = 0; mod4 = 0; sub = 0;
    endfunction

    function logic [31:0] h32(int o);
        return {hdr[o+3], hdr[o+2], hdr[o+1], hdr[o]};
    endfunction

    function void add(logic [1:0] k, logic [31:0] c, logic [31:0] r, logic [23:0] rgb,
                      logic [31:0] iw, logic [31:0] ih, logic [1:0] st);
        t_res x;
        x = '0;
        x.kind = k; x.col = c[11:0]; x.row = r[11:0];
        x.red = rgb[23:16]; x.green = rgb[15:8]; x.blue = rgb[7:0];
        x.image_width = iw[12:0]; x.image_height = ih[12:0]; x.status = st;
        exp_q.push_back(x);
        nres++;
    endfunction

    function void add_status(logic [1:0] st);
        if (nres < 8) add(KIND_STATUS, 0, 0, 0, 0, 0, st);
        else begin
            pend = 1; pend_st = st;
        end
    endfunction

    function void add_pixel(logic [23:0] rgb);
        add(KIND_PIXEL, colc, h - 1 - rowc, rgb, 0, 0, ST_OK);
        colc++;
    endfunction

    function void begin_data();
        colc = 0; rowc = 0; sub = 0; mod4 = 0; gb_acc = 0;
        if (w == 0 || h == 0) begin
            ph = PH_DONE;
            add_status(ST_OK);
        end else ph = PH_DAT;
    endfunction

    // returns 3 on an accepted header
    function int header_verdict();
        logic [31:0] sz, cmp, isz, bp, ww, hh, of, ent;
        logic [63:0] line;
        logic        idx;
        sz = h32(2); cmp = h32(30); isz = h32(14); bp = {16'd0, hdr[29], hdr[28]};
        ww = h32(18); hh = h32(22); of = h32(10);
        idx = (bp == 1 || bp == 4 || bp == 8);
        if (file_size < HDR_BYTES) return ST_INVALID;
        if (hdr[0] != SIG_B || hdr[1] != SIG_M) return ST_UNSUPPORTED;
        if (cmp != 0) return ST_UNSUPPORTED;
        if (isz != INFO_HDR) return ST_UNSUPPORTED;
        if (ww > MAX_DIM_DEF || hh > MAX_DIM_DEF) return ST_INVALID;
        line = ((64'(ww) * bp + 31) >> 3) & ~64'h3;
        if (line * hh > 64'hFFFF_FFFF) return ST_INVALID;
        if (sz != file_size || sz < of) return ST_INVALID;
        if (of < HDR_BYTES) return ST_INVALID;
        ent = bp == 1 ? 2 : bp == 4 ? 16 : bp == 8 ? 256 : 0;
        if (of > HDR_BYTES && of - HDR_BYTES != 4 * ent) return ST_INVALID;
        if (idx && of == HDR_BYTES) return ST_INVALID;
        if (!idx && bp != 24) return ST_UNSUPPORTED;
        w = ww; h = hh; bpp = bp; off = of;
        return 3;
    endfunction

    function void data_byte(logic [7:0] b);
        if (bpp == 1) begin
            for (int i = 0; i < 8 && colc < w; i++) add_pixel(pal[b[7-i]]);
        end else if (bpp == 4) begin
            add_pixel(pal[b[7:4]]);
            if (colc < w) add_pixel(pal[b[3:0]]);
        end else if (bpp == 8) begin
            add_pixel(pal[b]);
        end else begin
            if (sub == 0) begin
                gb_acc = b; sub = 1;
            end else if (sub == 1) begin
                gb_acc[15:8] = b; sub = 2;
            end else begin
                add_pixel({b, gb_acc[15:0]});
                sub = 0;
            end
        end
        mod4 = (mod4 + 1) & 3;
        if (colc >= w) begin
            colc = 0;
            rowc++;
            if (rowc >= h) begin
                ph = PH_DONE;
                add_status(ST_OK);
            end else if (mod4 != 0) ph = PH_PAD;
        end
    endfunction

    // note one accepted input byte
    function void note_byte(logic [7:0] b, logic lastb);
        int v, first;
        logic [31:0] k;
        first = exp_q.size();
        nres = 0;
        if (pend) begin
            pend = 0;
            add(KIND_STATUS, 0, 0, 0, 0, 0, pend_st);
        end
        case (ph)
            PH_HDR: begin
                if (nbytes < HDR_BYTES) hdr[nbytes] = b;
                nbytes++;
                if (nbytes >= HDR_BYTES) begin
                    v = header_verdict();
                    if (v != 3) begin
                        ph = PH_DONE;
                        add_status(v[1:0]);
                    end else begin
                        add(KIND_DIM, 0, 0, 0, w, h, ST_OK);
                        if (off == HDR_BYTES) begin_data();
                        else ph = PH_PAL;
                    end
                end
            end
            PH_PAL: begin
                k = nbytes - HDR_BYTES;
                case (k[1:0])
                    LANE_BLUE:  pal[k[9:2]][7:0] = b;
                    LANE_GREEN: pal[k[9:2]][15:8] = b;
                    LANE_RED:   pal[k[9:2]][23:16] = b;
                    default: ;
                endcase
                nbytes++;
                if (nbytes >= off) begin_data();
            end
            PH_DAT: data_byte(b);
            PH_PAD: begin
                mod4 = (mod4 + 1) & 3;
                if (mod4 == 0) ph = PH_DAT;
            end
            default: ;
        endcase
        if (lastb) begin
            if (ph != PH_DONE) add_status(ST_INVALID);
            restart();
        end
        if (exp_q.size() > first) exp_q[exp_q.size()-1].last = 1'b1;
    endfunction

    // compare one popped result with the oldest expected one
    function void check_result(t_res got);
        t_res e;
        if (exp_q.size() == 0) begin
            $display("%0t: unexpected result exp none act %p", $realtime, got);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        if (got.kind != e.kind) report("kind", e.kind, got.kind);
        if (got.col != e.col) report("col", e.col, got.col);
        if (got.row != e.row) report("row", e.row, got.row);
        if (got.red != e.red) report("red", e.red, got.red);
        if (got.green != e.green) report("green", e.green, got.green);
        if (got.blue != e.blue) report("blue", e.blue, got.blue);
        if (got.image_width != e.image_width)
            report("image_width", e.image_width, got.image_width);
        if (got.image_height != e.image_height)
            report("image_height", e.image_height, got.image_height);
        if (got.status != e.status) report("status", e.status, got.status);
        if (got.last != e.last) report("last", e.last, got.last);
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] a);
        $display("%0t: %s mismatch exp %0h act %0h", $realtime, f, e, a);
        errors++;
    endfunction
endclass

module tb_bmp_stream_to_rgb_pixels;
    logic        i_clk, i_rst_n;
    logic        push, full, empty, pop;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic [1:0]  o_kind, o_status;
    logic [11:0] o_col, o_row;
    logic [7:0]  o_red, o_green, o_blue;
    logic [12:0] o_image_width, o_image_height;
    logic        o_last;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    bmp_scoreboard pixel_board;
    logic [7:0]    file_bytes[$];
    longint        cycles;
    bit            rx_hold;
    int            rx_wait;

    bmp_stream_to_rgb_pixels i_dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial pixel_board = new();

    // timeout
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("tb_bmp_stream_to_rgb_pixels: FAIL");
                $finish;
            end
        end
    end

    // result side with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                t_res r;
                r = '{o_kind, o_col, o_row, o_red, o_green, o_blue,
                      o_image_width, o_image_height, o_status, o_last};
                pixel_board.check_result(r);
            end
            if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                pop <= 1'b0;
            end else if (pop && !empty) begin
                if (!rx_hold && $urandom_range(0, 2) == 0) begin
                    rx_wait <= $urandom_range(0, 12);
                    pop <= 1'b0;
                end
            end else pop <= 1'b1;
        end
    end

    task automatic cfg_write(logic [31:0] v);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= {REG_FILE_SIZE, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        pixel_board.file_size = v;
    endtask

    // send one byte, waiting on full
    task automatic send_byte(logic [7:0] b, logic lb);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1; i_data_byte <= b; i_last_byte <= lb;
        do @(posedge i_clk); while (full);
        pixel_board.note_byte(b, lb);
    endtask

    task automatic send_file(int cut);
        int n;
        n = file_bytes.size();
        if (cut > 0 && cut < n) n = cut;
        for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
        push <= 0;
    endtask

    task automatic drain();
        while (pixel_board.exp_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic void put32(int o, logic [31:0] v);
        for (int i = 0; i < 4; i++) file_bytes[o+i] = v[8*i +: 8];
    endfunction

    // build a well formed file in file_bytes, returns its size
    function automatic int build_file(int ww, int hh, int bp);
        int ent, rowb, sz;
        ent = bp == 1 ? 2 : bp == 4 ? 16 : bp == 8 ? 256 : 0;
        rowb = ((ww * bp + 31) >> 3) & ~3;
        sz = HDR_BYTES + 4 * ent + rowb * hh;
        file_bytes.delete();
        for (int i = 0; i < sz; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
        file_bytes[0] = SIG_B; file_bytes[1] = SIG_M;
        put32(2, sz); put32(10, HDR_BYTES + 4 * ent); put32(14, INFO_HDR);
        put32(18, ww); put32(22, hh);
        file_bytes[28] = 8'(bp); file_bytes[29] = 8'd0;
        put32(30, 0);
        return sz;
    endfunction

    function automatic int pick_bpp();
        case ($urandom_range(0, 3))
            0: return 1;
            1: return 4;
            2: return 8;
            default: return 24;
        endcase
    endfunction

    initial begin
        int sz, sent, bp, cut;
        i_rst_n = 0; push = 0; pop = 0; i_data_byte = 0; i_last_byte = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        rx_hold = 0; rx_wait = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        sent = 0;

        // directed: 1-bit file with eight-pixel bursts, no result stalls
        rx_hold = 1;
        sz = build_file(11, 1, 1); cfg_write(sz); send_file(0); sent += sz; drain();
        rx_hold = 0;
        // empty image, compression, bad depth, oversized width
        sz = build_file(0, 3, 24); cfg_write(sz); send_file(0); sent += sz; drain();
        sz = build_file(2, 2, 24); put32(30, 1); cfg_write(sz);
        send_file(HDR_BYTES); sent += HDR_BYTES; drain();
        sz = build_file(2, 2, 24); file_bytes[28] = 8'd16; cfg_write(sz);
        send_file(HDR_BYTES); sent += HDR_BYTES; drain();
        sz = build_file(5000, 1, 24); put32(2, 60); cfg_write(60); send_file(60);
        sent += 60; drain();

        // random: mostly good files, some corrupted or cut short
        while (sent < 400) begin
            bp = pick_bpp();
            sz = build_file($urandom_range(1, 9), $urandom_range(1, 4), bp);
            cut = 0;
            case ($urandom_range(0, 7))
                0: cut = $urandom_range(1, sz - 1);
                1: file_bytes[$urandom_range(0, 53)] = 8'($urandom_range(0, 255));
                2: file_bytes.push_back(8'($urandom_range(0, 255)));
                default: ;
            endcase
            // an 8-bit palette alone is over a thousand bytes, so cut those files
            if (bp == 8) cut = $urandom_range(1, 120);
            cfg_write($urandom_range(0, 9) == 0 ? sz + 1 : sz);
            send_file(cut);
            sent += (cut > 0) ? cut : file_bytes.size();
            drain();
        end

        if (pixel_board.errors == 0 && pixel_board.exp_q.size() == 0)
            $display("tb_bmp_stream_to_rgb_pixels: PASS");
        else
            $display("tb_bmp_stream_to_rgb_pixels: FAIL");
        $finish;
    end
endmodule

/* bmp_stream_to_rgb_pixels.f */
hdl/bmp_pkg.sv
hdl/bmp_fifo.sv
hdl/bmp_front.sv
hdl/bmp_back.sv
hdl/bmp_stream_to_rgb_pixels.sv
tb/tb_bmp_stream_to_rgb_pixels.sv
